// File: sv/ars_pkg.sv
// Shared types, constants and the term microprogram of the Apery residue scanner.
package ars_pkg;

  localparam int FIELD_W = 32;
  localparam int NBITS_W = 6;
  localparam int UPC_W   = 4;
  localparam int UC_LEN  = 13;
  localparam int MOD_MIN = 5;

  localparam int K_THREE = 3;
  localparam int K_27    = 27;
  localparam int K_34    = 34;
  localparam int K_51    = 51;
  localparam int K_FIVE  = 5;

  // nbits of zero in a micro-op means all bits of the operand
  localparam logic [NBITS_W-1:0] NB_FULL = '0;

  typedef enum logic [3:0] {
    S_J, S_J2, S_J3, S_OLD, S_NEW, S_T0, S_T1,
    S_ZERO, S_ONE, S_FIVE, S_K3, S_K27, S_K34, S_K51, S_PM1
  } src_e;

  typedef enum logic [2:0] {
    D_J, D_J2, D_J3, D_T0, D_T1, D_RES
  } dst_e;

  // One micro-op: dst = (a * b + c) mod p, scanning nbits of b from the top.
  typedef struct packed {
    src_e               a;
    src_e               b;
    src_e               c;
    dst_e               dst;
    logic [NBITS_W-1:0] nbits;
  } uop_t;

  typedef struct packed {
    logic               start;
    logic [NBITS_W-1:0] nbits;
  } mac_ctrl_t;

  // Term program. Multiplicand a is always a residue or one, addend c never exceeds p.
  function automatic uop_t ucode(input logic [UPC_W-1:0] upc);
    uop_t u;
    unique case (upc)
      4'd0:    u = '{a: S_J3,  b: S_J3,  c: S_ZERO, dst: D_T0,  nbits: NB_FULL}; // j^6
      4'd1:    u = '{a: S_J3,  b: S_K34, c: S_FIVE, dst: D_T1,  nbits: 6'd6};
      4'd2:    u = '{a: S_J2,  b: S_K51, c: S_T1,   dst: D_T1,  nbits: 6'd6};
      4'd3:    u = '{a: S_J,   b: S_K27, c: S_T1,   dst: D_T1,  nbits: 6'd5};
      4'd4:    u = '{a: S_NEW, b: S_T1,  c: S_ZERO, dst: D_T1,  nbits: NB_FULL};
      4'd5:    u = '{a: S_OLD, b: S_T0,  c: S_ZERO, dst: D_T0,  nbits: NB_FULL};
      // t1 - t2 taken as t2 * (p-1) + t1
      4'd6:    u = '{a: S_T0,  b: S_PM1, c: S_T1,   dst: D_RES, nbits: NB_FULL};
      4'd7:    u = '{a: S_J2,  b: S_K3,  c: S_J3,   dst: D_T1,  nbits: 6'd2};
      4'd8:    u = '{a: S_J,   b: S_K3,  c: S_T1,   dst: D_T1,  nbits: 6'd2};
      4'd9:    u = '{a: S_ONE, b: S_ONE, c: S_T1,   dst: D_J3,  nbits: 6'd1};
      4'd10:   u = '{a: S_J,   b: S_ONE, c: S_J2,   dst: D_T1,  nbits: 6'd1};
      4'd11:   u = '{a: S_J,   b: S_ONE, c: S_ONE,  dst: D_J,   nbits: 6'd1};
      4'd12:   u = '{a: S_J,   b: S_ONE, c: S_T1,   dst: D_J2,  nbits: 6'd1};
      default: u = '{a: S_ZERO, b: S_ZERO, c: S_ZERO, dst: D_T0, nbits: NB_FULL};
    endcase
    return u;
  endfunction

endpackage

// File: sv/ars_cfg_if.sv
// Configuration write channel carrying the modulus.
interface ars_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [ars_pkg::FIELD_W-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

// File: sv/ars_item_if.sv
// Input item channel: one tick, with the restart flag.
interface ars_item_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// File: sv/ars_term_if.sv
// Result item channel: one Apery term residue and its scan bookkeeping.
interface ars_term_if;
  logic                        valid;
  logic                        ready;
  logic [ars_pkg::FIELD_W-1:0] term_index;
  logic [ars_pkg::FIELD_W-1:0] term_residue;
  logic                        is_zero;
  logic [ars_pkg::FIELD_W-1:0] zero_total;
  logic                        last;

  modport source (output valid, output term_index, output term_residue, output is_zero,
                  output zero_total, output last, input ready);
  modport sink   (input valid, input term_index, input term_residue, input is_zero,
                  input zero_total, input last, output ready);
endinterface

// File: sv/apery_residue_zero_scanner.sv
// Top level: term sequencer, recurrence registers and output register of the scanner.
//
// Walks B_r mod p of the scaled Apery sequence, r = 0 .. p-1, one term per item.
// cfg_i writes the modulus p (low MOD_WIDTH bits, values below 5 become 5); a write
// ends the current scan. Write it only while the block is idle.
// item_i: each item yields exactly one result on term_o; restart = 1 begins a scan
// at r = 0, otherwise the next term follows. After the term with last = 1 the next
// item begins a new scan.
// Timing: the scan start term and the r = 1 term skip the program and pass from accept
// through the emit state into the output register. Every later term runs a 13-step
// program on the shared bit-serial multiply-add unit (one multiplier bit per cycle);
// that unit and the term-to-term recurrence set the rate, so one item is in flight
// at a time and item_i.ready is low while it is worked on.
// The result sits in an output register: a stalled term_o holds it steady while the
// next item is accepted and computed; that item then waits until the register frees.
// Reset: modulus 5, no result pending, and the first item starts a scan.
module apery_residue_zero_scanner #(
  parameter int MOD_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ars_cfg_if.sink    cfg_i,
  ars_item_if.sink   item_i,
  ars_term_if.source term_o
);
  import ars_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_EMIT} state_e;

  typedef struct packed {
    logic [MOD_WIDTH-1:0] j;
    logic [MOD_WIDTH-1:0] j2;
    logic [MOD_WIDTH-1:0] j3;
    logic [MOD_WIDTH-1:0] old_t;
    logic [MOD_WIDTH-1:0] new_t;
    logic [MOD_WIDTH-1:0] t0;
    logic [MOD_WIDTH-1:0] t1;
    logic [MOD_WIDTH-1:0] pm1;
  } regs_t;

  function automatic logic [MOD_WIDTH-1:0] pick(input src_e s, input regs_t r);
    logic [MOD_WIDTH-1:0] v;
    unique case (s)
      S_J:     v = r.j;
      S_J2:    v = r.j2;
      S_J3:    v = r.j3;
      S_OLD:   v = r.old_t;
      S_NEW:   v = r.new_t;
      S_T0:    v = r.t0;
      S_T1:    v = r.t1;
      S_ONE:   v = MOD_WIDTH'(1);
      S_FIVE:  v = MOD_WIDTH'(K_FIVE);
      S_K3:    v = MOD_WIDTH'(K_THREE);
      S_K27:   v = MOD_WIDTH'(K_27);
      S_K34:   v = MOD_WIDTH'(K_34);
      S_K51:   v = MOD_WIDTH'(K_51);
      S_PM1:   v = r.pm1;
      default: v = '0;
    endcase
    return v;
  endfunction

  state_e               state_q;
  logic                 ov_q;
  logic [UPC_W-1:0]     upc_q;
  logic [MOD_WIDTH-1:0] mod_q;
  logic                 scan_done_q;

  logic [MOD_WIDTH-1:0] j_q, j2_q, j3_q, old_q, new_q, t0_q, t1_q, res_q;
  logic [MOD_WIDTH-1:0] r_q, idx_q, zeros_q;
  logic [FIELD_W-1:0]   out_idx_q, out_res_q, out_zeros_q;
  logic                 out_zero_q, out_last_q;

  logic                 in_acc, cfg_acc, emit_go, start_scan, last_w;
  logic [MOD_WIDTH-1:0] cfg_val, mod_d, zeros_nx;
  uop_t                 uop;
  regs_t                regs;
  mac_ctrl_t            mac_ctrl;
  logic [MOD_WIDTH-1:0] mac_a, mac_b, mac_c, mac_res;
  logic                 mac_done;

  assign item_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign in_acc       = item_i.valid && item_i.ready;
  assign cfg_acc      = cfg_i.valid;
  assign emit_go      = (state_q == ST_EMIT) && (!ov_q || term_o.ready);
  assign start_scan   = item_i.restart || scan_done_q;
  assign last_w       = (r_q >= mod_q - 1'b1);
  assign zeros_nx     = zeros_q + MOD_WIDTH'(res_q == '0);

  assign cfg_val = cfg_i.modulus[MOD_WIDTH-1:0];
  assign mod_d   = (cfg_val < MOD_WIDTH'(MOD_MIN)) ? MOD_WIDTH'(MOD_MIN) : cfg_val;

  assign uop  = ucode(upc_q);
  assign regs = '{j: j_q, j2: j2_q, j3: j3_q, old_t: old_q, new_t: new_q,
                  t0: t0_q, t1: t1_q, pm1: mod_q - 1'b1};

  always_comb begin
    mac_a          = pick(uop.a, regs);
    mac_b          = pick(uop.b, regs);
    mac_c          = pick(uop.c, regs);
    mac_ctrl.start = (state_q == ST_ISSUE);
    mac_ctrl.nbits = (uop.nbits == NB_FULL) ? NBITS_W'(MOD_WIDTH) : uop.nbits;
  end

  ars_mac #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .c_i    (mac_c),
    .mod_i  (mod_q),
    .done_o (mac_done),
    .res_o  (mac_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ov_q        <= 1'b0;
      upc_q       <= '0;
      mod_q       <= MOD_WIDTH'(MOD_MIN);
      scan_done_q <= 1'b1;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            upc_q <= '0;
            if (start_scan || idx_q == MOD_WIDTH'(1)) begin
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mac_done) begin
            if (upc_q == UPC_W'(UC_LEN - 1)) begin
              state_q <= ST_EMIT;
            end else begin
              upc_q   <= upc_q + 1'b1;
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (emit_go) begin
        ov_q <= 1'b1;
      end else if (term_o.ready) begin
        ov_q <= 1'b0;
      end

      if (cfg_acc) begin
        mod_q       <= mod_d;
        scan_done_q <= 1'b1;
      end else if (emit_go) begin
        scan_done_q <= last_w;
      end
    end
  end

  // Recurrence registers and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (start_scan) begin
        r_q     <= '0;
        res_q   <= MOD_WIDTH'(1);
        old_q   <= MOD_WIDTH'(1);
        new_q   <= (mod_q == MOD_WIDTH'(MOD_MIN)) ? '0 : MOD_WIDTH'(K_FIVE);
        j_q     <= MOD_WIDTH'(1);
        j2_q    <= MOD_WIDTH'(1);
        j3_q    <= MOD_WIDTH'(1);
        zeros_q <= '0;
      end else begin
        r_q <= idx_q;
        if (idx_q == MOD_WIDTH'(1)) begin
          res_q <= new_q;
        end
      end
    end

    if (state_q == ST_WAIT && mac_done) begin
      unique case (uop.dst)
        D_J:   j_q  <= mac_res;
        D_J2:  j2_q <= mac_res;
        D_J3:  j3_q <= mac_res;
        D_T0:  t0_q <= mac_res;
        D_T1:  t1_q <= mac_res;
        D_RES: begin
          res_q <= mac_res;
          old_q <= new_q;
          new_q <= mac_res;
        end
        default: ;
      endcase
    end

    if (emit_go) begin
      zeros_q     <= zeros_nx;
      idx_q       <= r_q + 1'b1;
      out_idx_q   <= FIELD_W'(r_q);
      out_res_q   <= FIELD_W'(res_q);
      out_zero_q  <= (res_q == '0);
      out_zeros_q <= FIELD_W'(zeros_nx);
      out_last_q  <= last_w;
    end
  end

  assign term_o.valid        = ov_q;
  assign term_o.term_index   = out_idx_q;
  assign term_o.term_residue = out_res_q;
  assign term_o.is_zero      = out_zero_q;
  assign term_o.zero_total   = out_zeros_q;
  assign term_o.last         = out_last_q;

endmodule

// File: sv/ars_mac.sv
// Shared bit-serial modular multiply-add unit: (a * b + c) mod p.
module ars_mac #(
  parameter int MOD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ars_pkg::mac_ctrl_t    ctrl_i,
  input  logic [MOD_WIDTH-1:0]  a_i,
  input  logic [MOD_WIDTH-1:0]  b_i,
  input  logic [MOD_WIDTH-1:0]  c_i,
  input  logic [MOD_WIDTH-1:0]  mod_i,
  output logic                  done_o,
  output logic [MOD_WIDTH-1:0]  res_o
);
  import ars_pkg::*;

  localparam int CNT_W = $clog2(MOD_WIDTH);
  localparam int SUM_W = MOD_WIDTH + 2;

  logic                 busy_q;
  logic                 add_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [MOD_WIDTH-1:0] acc_q;
  logic [MOD_WIDTH-1:0] acc_d;
  logic [SUM_W-1:0]     base;
  logic [SUM_W-1:0]     addend;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     mod_x1;
  logic [SUM_W-1:0]     mod_x2;

  // Operands are held steady by the sequencer for the whole operation.
  // Doubling step: 2*acc + a < 3p; final add step: acc + c < 2p.
  always_comb begin
    mod_x1 = SUM_W'(mod_i);
    mod_x2 = {1'b0, mod_i, 1'b0};
    base   = add_q ? SUM_W'(acc_q) : {1'b0, acc_q, 1'b0};
    addend = add_q ? SUM_W'(c_i) : (b_i[cnt_q] ? SUM_W'(a_i) : '0);
    sum    = base + addend;
    priority if (sum >= mod_x2) begin
      acc_d = MOD_WIDTH'(sum - mod_x2);
    end else if (sum >= mod_x1) begin
      acc_d = MOD_WIDTH'(sum - mod_x1);
    end else begin
      acc_d = MOD_WIDTH'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      add_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        add_q  <= 1'b0;
        cnt_q  <= CNT_W'(ctrl_i.nbits - 1'b1);
      end else if (busy_q) begin
        if (add_q) begin
          busy_q <= 1'b0;
          add_q  <= 1'b0;
          done_q <= 1'b1;
        end else if (cnt_q == '0) begin
          add_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

// File: sv/ars_checker.sv
// Port-level checks of the scanner and their binding to the top level.
module ars_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ars_pkg::FIELD_W-1:0] term_index_i,
  input logic [ars_pkg::FIELD_W-1:0] term_residue_i,
  input logic                        is_zero_i,
  input logic [ars_pkg::FIELD_W-1:0] zero_total_i
);
  import ars_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(term_index_i) && $stable(term_residue_i)
                                    && $stable(zero_total_i))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in flight");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_zero_i == (term_residue_i == '0)) && (!is_zero_i || zero_total_i != '0))
    else $error("zero flag or zero count inconsistent with residue");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && term_index_i == '0 |-> term_residue_i == FIELD_W'(1) && zero_total_i == '0)
    else $error("scan start term wrong");

endmodule

bind apery_residue_zero_scanner ars_checker u_ars_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (item_i.valid),
  .in_ready_i     (item_i.ready),
  .out_valid_i    (term_o.valid),
  .out_ready_i    (term_o.ready),
  .term_index_i   (term_o.term_index),
  .term_residue_i (term_o.term_residue),
  .is_zero_i      (term_o.is_zero),
  .zero_total_i   (term_o.zero_total)
);

// File: tb/tb_apery_residue_zero_scanner.sv
// Testbench for apery_residue_zero_scanner: directed and random scans checked against a predictor.
module tb_apery_residue_zero_scanner;
  import ars_pkg::*;

  localparam int MOD_W        = 32;
  localparam int TERM_LATENCY = 4 * MOD_W + 65;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct {
    logic [FIELD_W-1:0] index;
    logic [FIELD_W-1:0] residue;
    logic               zero;
    logic [FIELD_W-1:0] zero_total;
    logic               last;
  } term_t;

  logic clk;
  logic rst_n;

  ars_cfg_if  cfg ();
  ars_item_if item ();
  ars_term_if term ();

  apery_residue_zero_scanner #(.MOD_WIDTH(MOD_W)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg),
    .item_i (item),
    .term_o (term)
  );

  // predictor state
  logic [FIELD_W-1:0] cur_mod;
  logic [FIELD_W-1:0] next_r;
  logic [FIELD_W-1:0] term_prev2;
  logic [FIELD_W-1:0] term_prev1;
  logic [FIELD_W-1:0] r_lin;
  logic [FIELD_W-1:0] r_sq;
  logic [FIELD_W-1:0] r_cu;
  logic [FIELD_W-1:0] zero_run;
  logic               scan_over;

  term_t expected_terms[$];

  int    mismatches;
  int    terms_checked;
  int    zeros_seen;
  int    scans_done;
  int    moduli_used;
  int    cycles;
  int    hold_request;
  bit    gaps_on;
  bit    stalls_on;
  bit    offering;

  logic [FIELD_W-1:0] small_primes [0:11] = '{5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43};

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("apery_residue_zero_scanner: mismatch");
      $finish;
    end
  end

  function automatic void reset_predictor();
    cur_mod    = K_FIVE;
    next_r     = '0;
    term_prev2 = 1;
    term_prev1 = K_FIVE;
    r_lin      = 1;
    r_sq       = 1;
    r_cu       = 1;
    zero_run   = '0;
    scan_over  = 1'b1;
  endfunction

  function automatic void load_modulus(input logic [FIELD_W-1:0] value);
    logic [63:0] v;
    v = {32'd0, value} & ((64'd1 << MOD_W) - 64'd1);
    if (v < 64'(MOD_MIN)) v = 64'(MOD_MIN);
    cur_mod   = v[FIELD_W-1:0];
    scan_over = 1'b1;
  endfunction

  // Next term of the scaled Apery recurrence mod p; powers of j = r-1 advance by differences.
  function automatic term_t next_apery_term(input logic restart);
    term_t       t;
    logic [63:0] m, j, j2, j3, j6, poly, t1, t2, res, r;
    m  = {32'd0, cur_mod};
    j  = {32'd0, r_lin};
    j2 = {32'd0, r_sq};
    j3 = {32'd0, r_cu};
    if (restart || scan_over) begin
      r          = 0;
      res        = 64'd1 % m;
      term_prev2 = res[FIELD_W-1:0];
      term_prev1 = FIELD_W'(64'(K_FIVE) % m);
      r_lin      = FIELD_W'(64'd1 % m);
      r_sq       = r_lin;
      r_cu       = r_lin;
      zero_run   = '0;
      scan_over  = 1'b0;
    end else if (next_r == 1) begin
      r   = 1;
      res = {32'd0, term_prev1};
    end else begin
      j6   = (j3 * j3) % m;
      poly = (K_34 * j3 + K_51 * j2 + K_27 * j + K_FIVE) % m;
      t1   = (poly * {32'd0, term_prev1}) % m;
      t2   = (j6 * {32'd0, term_prev2}) % m;
      res  = (t1 >= t2) ? (t1 - t2) : (t1 + m - t2);
      r    = {32'd0, next_r};
      term_prev2 = term_prev1;
      term_prev1 = res[FIELD_W-1:0];
      r_cu  = FIELD_W'((j3 + K_THREE * j2 + K_THREE * j + 1) % m);
      r_sq  = FIELD_W'((j2 + 2 * j + 1) % m);
      r_lin = FIELD_W'((j + 1) % m);
    end
    if (res == 0) zero_run++;
    next_r = r[FIELD_W-1:0] + 1;
    t.index      = r[FIELD_W-1:0];
    t.residue    = res[FIELD_W-1:0];
    t.zero       = (res == 0);
    t.zero_total = zero_run;
    t.last       = (r >= m - 1);
    if (t.last) scan_over = 1'b1;
    return t;
  endfunction

  task automatic send_tick(input logic restart);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      if (offering) begin
        item.valid <= 1'b0;
        offering = 0;
      end
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item.valid   <= 1'b1;
    item.restart <= restart;
    offering = 1;
    do @(posedge clk); while (!item.ready);
    expected_terms.push_back(next_apery_term(restart));
  endtask

  task automatic wait_drained();
    if (offering) begin
      item.valid <= 1'b0;
      offering = 0;
    end
    while (expected_terms.size() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [FIELD_W-1:0] value);
    wait_drained();
    cfg.valid   <= 1'b1;
    cfg.modulus <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    load_modulus(value);
    moduli_used++;
  endtask

  // receiver: random stall bursts, plus a long hold when asked
  initial begin
    int hold_count;
    int stall_count;
    hold_count  = 0;
    stall_count = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_count   = hold_request;
        hold_request = 0;
      end
      if (hold_count > 0) begin
        term.ready <= 1'b0;
        hold_count--;
      end else if (stall_count > 0) begin
        term.ready <= 1'b0;
        stall_count--;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        term.ready <= 1'b0;
        stall_count = $urandom_range(0, 2);
      end else begin
        term.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input logic [FIELD_W-1:0] want,
                                      input logic [FIELD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    term_t want;
    if (rst_n && term.valid && term.ready) begin
      if (expected_terms.size() == 0) begin
        $error("term_o: unexpected item, index %0d residue %0d", term.term_index,
               term.term_residue);
        mismatches++;
      end else begin
        want = expected_terms.pop_front();
        check_field("term_index", want.index, term.term_index);
        check_field("term_residue", want.residue, term.term_residue);
        check_field("is_zero", FIELD_W'(want.zero), FIELD_W'(term.is_zero));
        check_field("zero_total", want.zero_total, term.zero_total);
        check_field("last", FIELD_W'(want.last), FIELD_W'(term.last));
        terms_checked++;
        if (term.is_zero) zeros_seen++;
        if (term.last) scans_done++;
      end
    end
  end

  // reset value p = 5: full scan to the last mark, then the wrap into a new scan
  task automatic test_reset_scan();
    repeat (7) send_tick(1'b0);
  endtask

  task automatic test_restart_mid_scan();
    write_modulus(32'd4294967291);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // masking of tiny values, all-ones composite, and a write that abandons a scan
  task automatic test_modulus_writes();
    write_modulus(32'd0);
    send_tick(1'b0);
    send_tick(1'b0);
    write_modulus(32'hFFFF_FFFF);
    repeat (3) send_tick(1'b0);
    write_modulus(32'd7);
    repeat (3) send_tick(1'b0);
    write_modulus(32'd7);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_output_backpressure();
    write_modulus(32'd11);
    hold_request = 1200;
    repeat (6) send_tick(1'b0);
    wait_drained();
    repeat (6) send_tick(1'b0);
  endtask

  task automatic test_random_scans();
    int sent;
    int pick;
    logic [FIELD_W-1:0] m;
    sent = 0;
    while (sent < 370) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      m = small_primes[$urandom_range(0, 11)];
      else if (pick < 70) m = $urandom_range(5, 64);
      else if (pick < 90) m = $urandom;
      else                m = $urandom_range(0, 4);
      write_modulus(m);
      repeat ($urandom_range(6, 50)) begin
        send_tick($urandom_range(0, 29) == 0);
        sent++;
      end
    end
  endtask

  task automatic test_steady_stream();
    gaps_on   = 0;
    stalls_on = 0;
    write_modulus(32'd13);
    repeat (45) send_tick($urandom_range(0, 39) == 0);
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg.valid    = 1'b0;
    cfg.modulus  = '0;
    item.valid   = 1'b0;
    item.restart = 1'b0;
    term.ready   = 1'b0;
    mismatches    = 0;
    terms_checked = 0;
    zeros_seen    = 0;
    scans_done    = 0;
    moduli_used   = 1;
    cycles        = 0;
    hold_request  = 0;
    gaps_on       = 1;
    stalls_on     = 1;
    offering      = 0;
    reset_predictor();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_scan();
    test_restart_mid_scan();
    test_modulus_writes();
    test_output_backpressure();
    test_random_scans();
    test_steady_stream();

    wait_drained();
    repeat (2 * TERM_LATENCY) @(posedge clk);
    if (expected_terms.size() != 0) begin
      $error("term_o: %0d expected items never arrived", expected_terms.size());
      mismatches++;
    end
    $display("checked %0d terms under %0d modulus settings", terms_checked, moduli_used);
    $display("saw %0d zero residues and %0d completed scans", zeros_seen, scans_done);
    if (mismatches == 0) begin
      $display("apery_residue_zero_scanner: match");
    end else begin
      $display("apery_residue_zero_scanner: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
sv/ars_pkg.sv
sv/ars_cfg_if.sv
sv/ars_item_if.sv
sv/ars_term_if.sv
sv/ars_mac.sv
sv/apery_residue_zero_scanner.sv
sv/ars_checker.sv
tb/tb_apery_residue_zero_scanner.sv
